// ===== src/ghi_pkg.sv =====
// Package for the grid height interpolator: widths, store depth, command codes,
// controller/datapath command and status structs. No dependencies.
package ghi_pkg;
  localparam int COORD_WIDTH = 32;
  localparam int MAX_COLUMNS = 64;
  localparam int MAX_ROWS = 64;
  localparam int ADDR_WIDTH = 12;
  localparam int STORE_DEPTH = 1 << ADDR_WIDTH;
  localparam int CFG_WIDTH = 7;
  localparam int DIM_WIDTH = 9;
  localparam int MAG_WIDTH = COORD_WIDTH + 1;
  localparam int PROD_WIDTH = 2 * MAG_WIDTH;
  localparam int QUOT_LIMIT_LOG = 2 * COORD_WIDTH - 2;
  localparam int DIV_CNT_WIDTH = $clog2(PROD_WIDTH + 1);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [0:0] REG_COLUMNS = 1'b0;
  localparam logic [0:0] REG_ROWS = 1'b1;

  typedef enum logic [2:0] {
    RD_SRC_QX = 3'd0,
    RD_SRC_QZ = 3'd1,
    RD_K0M    = 3'd2,
    RD_K0     = 3'd3,
    RD_K1M    = 3'd4,
    RD_K1     = 3'd5
  } rd_sel_t;

  typedef enum logic [2:0] {
    LERP_ROW0 = 3'd0,
    LERP_ROW1 = 3'd1,
    LERP_COL  = 3'd2,
    LERP_NONE = 3'd3
  } lerp_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic        load_query;
    logic        write_node;
    logic        init_search;
    logic        rd_issue;
    rd_sel_t     rd_what;
    logic        rd_capture;
    logic        step_i;
    logic        step_j;
    logic        lerp_start;
    lerp_sel_t   lerp_sel;
    logic        lerp_save;
    logic        out_load;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic i_more;   // qx > x[i] and i < cols-1
    logic j_more;
    logic zero_span;
    logic div_done;
  } dp_status_t;

  function automatic logic signed [COORD_WIDTH-1:0] sat_coord(
      input logic signed [COORD_WIDTH+1:0] v);
    logic signed [COORD_WIDTH+1:0] hi;
    logic signed [COORD_WIDTH+1:0] lo;
    hi = (COORD_WIDTH+2)'({1'b0, {(COORD_WIDTH-1){1'b1}}});
    lo = -hi - 1;
    if (v > hi) sat_coord = hi[COORD_WIDTH-1:0];
    else if (v < lo) sat_coord = lo[COORD_WIDTH-1:0];
    else sat_coord = v[COORD_WIDTH-1:0];
  endfunction
endpackage

// ===== src/grid_height_interpolator_unit.sv =====
// Grid height interpolator top level: controller plus datapath.
// A query's result follows the two searches, the node fetch and the bit-serial divider
// (one divide per lerp step); the controller then passes S_IWAIT before the next request
// is taken. Synchronous reset clears control and sets both registers to 2; stores are
// not cleared. Depends on ghi_pkg, ghi_controller, ghi_datapath.
module grid_height_interpolator_unit (
  input  logic clk,
  input  logic rst,
  input  logic valid_in,
  output logic stall_in,
  input  logic command,
  input  logic [ghi_pkg::ADDR_WIDTH-1:0] node_index,
  input  logic signed [ghi_pkg::COORD_WIDTH-1:0] node_x,
  input  logic signed [ghi_pkg::COORD_WIDTH-1:0] node_height,
  input  logic signed [ghi_pkg::COORD_WIDTH-1:0] node_z,
  input  logic signed [ghi_pkg::COORD_WIDTH-1:0] query_x,
  input  logic signed [ghi_pkg::COORD_WIDTH-1:0] query_y,
  input  logic signed [ghi_pkg::COORD_WIDTH-1:0] query_z,
  output logic valid_out,
  input  logic stall_out,
  output logic signed [ghi_pkg::COORD_WIDTH-1:0] surface_height,
  output logic in_material,
  output logic divide_by_zero,
  input  logic cfg_write,
  input  logic [0:0] cfg_index,
  input  logic [ghi_pkg::CFG_WIDTH-1:0] cfg_data
);
  logic [ghi_pkg::CFG_WIDTH-1:0] grid_columns, grid_rows;
  ghi_pkg::dp_cmd_t cmd;
  ghi_pkg::dp_status_t status;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_columns <= ghi_pkg::CFG_WIDTH'(2);
      grid_rows <= ghi_pkg::CFG_WIDTH'(2);
    end else if (cfg_write) begin
      case (cfg_index)
        ghi_pkg::REG_COLUMNS: grid_columns <= cfg_data;
        ghi_pkg::REG_ROWS: grid_rows <= cfg_data;
        default: ;
      endcase
    end
  end

  ghi_controller u_ctrl (
    .clk(clk), .rst(rst), .in_valid(valid_in), .in_stall(stall_in), .command(command),
    .out_valid(valid_out), .out_stall(stall_out), .cmd(cmd), .status(status)
  );

  ghi_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .status(status),
    .cfg_columns(grid_columns), .cfg_rows(grid_rows),
    .node_index(node_index), .node_x(node_x), .node_height(node_height), .node_z(node_z),
    .query_x(query_x), .query_y(query_y), .query_z(query_z),
    .surface_height(surface_height), .in_material(in_material),
    .divide_by_zero(divide_by_zero)
  );
endmodule

// ===== src/ghi_divider.sv =====
// Restoring divider, one quotient bit per cycle, with the saturating clamp.
// Depends on ghi_pkg.
module ghi_divider (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [ghi_pkg::PROD_WIDTH-1:0] numer,
  input  logic [ghi_pkg::MAG_WIDTH-1:0] denom,
  output logic done,
  output logic [ghi_pkg::QUOT_LIMIT_LOG:0] quot
);
  logic [ghi_pkg::PROD_WIDTH-1:0] shreg;
  logic [ghi_pkg::PROD_WIDTH-1:0] q;
  logic [ghi_pkg::MAG_WIDTH:0] rem;
  logic [ghi_pkg::MAG_WIDTH:0] rem_sh;
  logic [ghi_pkg::MAG_WIDTH-1:0] d;
  logic [ghi_pkg::DIV_CNT_WIDTH-1:0] cnt;
  logic busy;
  localparam logic [ghi_pkg::PROD_WIDTH-1:0] LIMIT =
    ghi_pkg::PROD_WIDTH'(1) << ghi_pkg::QUOT_LIMIT_LOG;

  assign rem_sh = {rem[ghi_pkg::MAG_WIDTH-1:0], shreg[ghi_pkg::PROD_WIDTH-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= ghi_pkg::DIV_CNT_WIDTH'(ghi_pkg::PROD_WIDTH);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == ghi_pkg::DIV_CNT_WIDTH'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg <= numer;
      d <= denom;
      rem <= '0;
      q <= '0;
    end else if (busy) begin
      shreg <= shreg << 1;
      if (rem_sh >= {1'b0, d}) begin
        rem <= rem_sh - {1'b0, d};
        q <= {q[ghi_pkg::PROD_WIDTH-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q <= {q[ghi_pkg::PROD_WIDTH-2:0], 1'b0};
      end
    end
  end

  assign quot = (q > LIMIT) ? LIMIT[ghi_pkg::QUOT_LIMIT_LOG:0]
                            : q[ghi_pkg::QUOT_LIMIT_LOG:0];
endmodule

// ===== src/ghi_datapath.sv =====
// Grid stores, search indexes, address generation and the lerp arithmetic.
// Depends on ghi_pkg and ghi_divider.
module ghi_datapath (
  input  logic clk,
  input  logic rst,
  input  ghi_pkg::dp_cmd_t cmd,
  output ghi_pkg::dp_status_t status,
  input  logic [ghi_pkg::CFG_WIDTH-1:0] cfg_columns,
  input  logic [ghi_pkg::CFG_WIDTH-1:0] cfg_rows,
  input  logic [ghi_pkg::ADDR_WIDTH-1:0] node_index,
  input  logic signed [ghi_pkg::COORD_WIDTH-1:0] node_x,
  input  logic signed [ghi_pkg::COORD_WIDTH-1:0] node_height,
  input  logic signed [ghi_pkg::COORD_WIDTH-1:0] node_z,
  input  logic signed [ghi_pkg::COORD_WIDTH-1:0] query_x,
  input  logic signed [ghi_pkg::COORD_WIDTH-1:0] query_y,
  input  logic signed [ghi_pkg::COORD_WIDTH-1:0] query_z,
  output logic signed [ghi_pkg::COORD_WIDTH-1:0] surface_height,
  output logic in_material,
  output logic divide_by_zero
);
  localparam int W = ghi_pkg::COORD_WIDTH;
  localparam int DW = ghi_pkg::DIM_WIDTH;
  localparam int AW = ghi_pkg::ADDR_WIDTH;

  logic signed [W-1:0] x_mem [ghi_pkg::STORE_DEPTH];
  logic signed [W-1:0] h_mem [ghi_pkg::STORE_DEPTH];
  logic signed [W-1:0] z_mem [ghi_pkg::STORE_DEPTH];
  logic signed [W-1:0] rd_x, rd_h, rd_z;
  logic [AW-1:0] rd_addr;
  ghi_pkg::rd_sel_t rd_what_q;

  logic signed [W-1:0] qx, qy, qz;
  logic [DW-1:0] cols, rows, i_idx, j_idx;
  logic [2*DW-1:0] row_base;
  logic signed [W-1:0] x0m, x0, x1m, x1, h0m, h0n, h1m, h1n, z0, z1;
  logic signed [W-1:0] hr0, hr1;

  // clamp registers to 2..MAX
  always_comb begin
    if (cfg_columns < 7'd2) cols = DW'(2);
    else if (32'(cfg_columns) > ghi_pkg::MAX_COLUMNS) cols = DW'(ghi_pkg::MAX_COLUMNS);
    else cols = DW'(cfg_columns);
    if (cfg_rows < 7'd2) rows = DW'(2);
    else if (32'(cfg_rows) > ghi_pkg::MAX_ROWS) rows = DW'(ghi_pkg::MAX_ROWS);
    else rows = DW'(cfg_rows);
  end

  // row_base tracks j*cols while searching, so no multiplier sits in the address path
  always_comb begin
    case (cmd.rd_what)
      ghi_pkg::RD_SRC_QX: rd_addr = AW'(i_idx);
      ghi_pkg::RD_SRC_QZ: rd_addr = AW'(row_base + (2*DW)'(i_idx));
      ghi_pkg::RD_K0M: rd_addr = AW'(row_base - (2*DW)'(cols) + (2*DW)'(i_idx) - 1'b1);
      ghi_pkg::RD_K0: rd_addr = AW'(row_base - (2*DW)'(cols) + (2*DW)'(i_idx));
      ghi_pkg::RD_K1M: rd_addr = AW'(row_base + (2*DW)'(i_idx) - 1'b1);
      default: rd_addr = AW'(row_base + (2*DW)'(i_idx));
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.write_node) begin
      x_mem[node_index] <= node_x;
      h_mem[node_index] <= node_height;
      z_mem[node_index] <= node_z;
    end
    if (cmd.rd_issue) begin
      rd_x <= x_mem[rd_addr];
      rd_h <= h_mem[rd_addr];
      rd_z <= z_mem[rd_addr];
      rd_what_q <= cmd.rd_what;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      qx <= query_x;
      qy <= query_y;
      qz <= query_z;
    end
    if (cmd.init_search) begin
      i_idx <= DW'(1);
      j_idx <= DW'(1);
      row_base <= (2*DW)'(cols);
    end
    if (cmd.step_i) i_idx <= i_idx + 1'b1;
    if (cmd.step_j) begin
      j_idx <= j_idx + 1'b1;
      row_base <= row_base + (2*DW)'(cols);
    end
    if (cmd.rd_capture) begin
      case (rd_what_q)
        ghi_pkg::RD_K0M: begin x0m <= rd_x; h0m <= rd_h; end
        ghi_pkg::RD_K0: begin x0 <= rd_x; h0n <= rd_h; z0 <= rd_z; end
        ghi_pkg::RD_K1M: begin x1m <= rd_x; h1m <= rd_h; end
        ghi_pkg::RD_K1: begin x1 <= rd_x; h1n <= rd_h; z1 <= rd_z; end
        default: ;
      endcase
    end
  end

  assign status.i_more = (i_idx < cols - 1'b1) && (qx > rd_x);
  assign status.j_more = (j_idx < rows - 1'b1) && (qz > rd_z);
  assign status.zero_span = (x0 == x0m) || (x1 == x1m) || (z1 == z0);

  // operand select for one lerp step
  logic signed [W-1:0] base, vhi, vlo, p, plo, shi, slo;
  always_comb begin
    case (cmd.lerp_sel)
      ghi_pkg::LERP_ROW0: begin
        base = h0m; vhi = h0n; vlo = h0m; p = qx; plo = x0m; shi = x0; slo = x0m;
      end
      ghi_pkg::LERP_ROW1: begin
        base = h1m; vhi = h1n; vlo = h1m; p = qx; plo = x1m; shi = x1; slo = x1m;
      end
      default: begin
        base = hr0; vhi = hr1; vlo = hr0; p = qz; plo = z0; shi = z1; slo = z0;
      end
    endcase
  end

  logic signed [W:0] dv, dp, ds;
  logic [ghi_pkg::MAG_WIDTH-1:0] mv, mp, ms;
  logic [ghi_pkg::PROD_WIDTH-1:0] prod;
  logic [ghi_pkg::MAG_WIDTH-1:0] span_q;
  logic neg_q, neg;
  logic signed [W-1:0] base_q;
  logic mul_go, div_start, div_done;
  logic [ghi_pkg::QUOT_LIMIT_LOG:0] quot;

  assign dv = (W+1)'(vhi) - (W+1)'(vlo);
  assign dp = (W+1)'(p) - (W+1)'(plo);
  assign ds = (W+1)'(shi) - (W+1)'(slo);
  assign mv = dv[W] ? ghi_pkg::MAG_WIDTH'(-dv) : ghi_pkg::MAG_WIDTH'(dv);
  assign mp = dp[W] ? ghi_pkg::MAG_WIDTH'(-dp) : ghi_pkg::MAG_WIDTH'(dp);
  assign ms = ds[W] ? ghi_pkg::MAG_WIDTH'(-ds) : ghi_pkg::MAG_WIDTH'(ds);
  assign neg = dv[W] ^ dp[W] ^ ds[W];

  // operands are registered, then the product, then the divider runs
  logic [ghi_pkg::MAG_WIDTH-1:0] mv_q, mp_q;
  always_ff @(posedge clk) begin
    if (rst) begin
      mul_go <= 1'b0;
      div_start <= 1'b0;
    end else begin
      mul_go <= cmd.lerp_start;
      div_start <= mul_go;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.lerp_start) begin
      mv_q <= mv; mp_q <= mp; span_q <= ms; neg_q <= neg; base_q <= base;
    end
    if (mul_go) prod <= mv_q * mp_q;
  end

  ghi_divider u_div (
    .clk(clk), .rst(rst), .start(div_start), .numer(prod), .denom(span_q),
    .done(div_done), .quot(quot)
  );
  assign status.div_done = div_done;

  logic signed [W+1:0] sum;
  logic signed [W-1:0] step_res;
  always_comb begin
    if (neg_q) sum = (W+2)'(base_q) - (W+2)'(signed'({1'b0, quot[W:0]}));
    else sum = (W+2)'(base_q) + (W+2)'(signed'({1'b0, quot[W:0]}));
    // any quotient at or beyond 2^W saturates regardless of base
    if (|quot[ghi_pkg::QUOT_LIMIT_LOG:W])
      sum = neg_q ? -(W+2)'(signed'({2'b01, {W{1'b0}}})) : (W+2)'(signed'({2'b01, {W{1'b0}}}));
    step_res = ghi_pkg::sat_coord(sum);
  end

  always_ff @(posedge clk) begin
    if (cmd.lerp_save) begin
      case (cmd.lerp_sel)
        ghi_pkg::LERP_ROW0: hr0 <= step_res;
        ghi_pkg::LERP_ROW1: hr1 <= step_res;
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      if (status.zero_span) begin
        surface_height <= '0;
        in_material <= 1'b0;
        divide_by_zero <= 1'b1;
      end else begin
        surface_height <= step_res;
        in_material <= qy < step_res;
        divide_by_zero <= 1'b0;
      end
    end
  end
endmodule

// ===== src/ghi_controller.sv =====
// Sequencer for writes, the two grid searches, node fetch and three lerp steps.
// Depends on ghi_pkg.
module ghi_controller (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  logic command,
  output logic out_valid,
  input  logic out_stall,
  output ghi_pkg::dp_cmd_t cmd,
  input  ghi_pkg::dp_status_t status
);
  typedef enum logic [10:0] {
    S_IDLE   = 11'b00000000001,
    S_IRD    = 11'b00000000010,
    S_IWAIT  = 11'b00000000100,
    S_ICHK   = 11'b00000001000,
    S_JRD    = 11'b00000010000,
    S_JWAIT  = 11'b00000100000,
    S_JCHK   = 11'b00001000000,
    S_FETCH  = 11'b00010000000,
    S_CHK0   = 11'b00100000000,
    S_LERP   = 11'b01000000000,
    S_WAIT   = 11'b10000000000
  } state_t;

  state_t state, state_next;
  logic [2:0] fetch, fetch_next;
  ghi_pkg::lerp_sel_t lsel, lsel_next;
  logic out_valid_next;

  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fetch <= '0;
      lsel <= ghi_pkg::LERP_ROW0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      fetch <= fetch_next;
      lsel <= lsel_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    fetch_next = fetch;
    lsel_next = lsel;
    out_valid_next = out_valid && out_stall;
    cmd = '0;
    cmd.lerp_sel = lsel;
    cmd.rd_what = ghi_pkg::RD_SRC_QX;
    case (state)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          if (command == ghi_pkg::CMD_WRITE) cmd.write_node = 1'b1;
          else begin
            cmd.load_query = 1'b1;
            cmd.init_search = 1'b1;
            state_next = S_IRD;
          end
        end
      end
      S_IRD: begin
        cmd.rd_what = ghi_pkg::RD_SRC_QX; cmd.rd_issue = 1'b1; state_next = S_ICHK;
      end
      S_ICHK: begin
        if (status.i_more) begin cmd.step_i = 1'b1; state_next = S_IRD; end
        else state_next = S_JRD;
      end
      S_JRD: begin
        cmd.rd_what = ghi_pkg::RD_SRC_QZ; cmd.rd_issue = 1'b1; state_next = S_JCHK;
      end
      S_JCHK: begin
        if (status.j_more) begin cmd.step_j = 1'b1; state_next = S_JRD; end
        else begin fetch_next = ghi_pkg::RD_K0M; state_next = S_FETCH; end
      end
      S_FETCH: begin
        // issue reads k0-1, k0, k1-1, k1; capture each in the cycle after its issue
        if (fetch <= ghi_pkg::RD_K1) begin
          cmd.rd_what = ghi_pkg::rd_sel_t'(fetch);
          cmd.rd_issue = 1'b1;
        end
        if (fetch >= ghi_pkg::RD_K0) cmd.rd_capture = 1'b1;
        fetch_next = fetch + 1'b1;
        if (fetch == 3'd6) state_next = S_CHK0;
      end
      S_CHK0: begin
        if (status.zero_span) begin
          cmd.out_load = 1'b1;
          out_valid_next = 1'b1;
          state_next = S_IWAIT;
        end else begin
          lsel_next = ghi_pkg::LERP_ROW0;
          state_next = S_LERP;
        end
      end
      S_LERP: begin cmd.lerp_start = 1'b1; state_next = S_WAIT; end
      S_WAIT: begin
        if (status.div_done) begin
          if (lsel == ghi_pkg::LERP_COL) begin
            cmd.out_load = 1'b1;
            out_valid_next = 1'b1;
            state_next = S_IWAIT;
          end else begin
            cmd.lerp_save = 1'b1;
            lsel_next = (lsel == ghi_pkg::LERP_ROW0) ? ghi_pkg::LERP_ROW1 : ghi_pkg::LERP_COL;
            state_next = S_LERP;
          end
        end
      end
      S_IWAIT: begin
        // hold until the previous result is taken
        if (!(out_valid && out_stall)) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

// ===== src/ghi_checker.sv =====
// Port-level checks for the grid height interpolator, bound to the top level.
// Depends on ghi_pkg and the grid_height_interpolator_unit ports.
module ghi_port_checks (
  input logic clk,
  input logic rst,
  input logic valid_in,
  input logic stall_in,
  input logic command,
  input logic valid_out,
  input logic stall_out,
  input logic [ghi_pkg::COORD_WIDTH-1:0] surface_height,
  input logic in_material,
  input logic divide_by_zero
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    valid_out && stall_out |=> valid_out && $stable(surface_height))
    else $error("result dropped while stalled");
  a_dz_zero: assert property (@(posedge clk) disable iff (rst)
    valid_out && divide_by_zero |-> surface_height == 0 && !in_material)
    else $error("zero span result not cleared");
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    valid_in && !stall_in && command == ghi_pkg::CMD_WRITE && !valid_out |=> !valid_out)
    else $error("write produced a result");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    valid_in && !stall_in && command == ghi_pkg::CMD_QUERY |=> stall_in)
    else $error("query in flight but input open");
endmodule

bind grid_height_interpolator_unit ghi_port_checks u_chk (
  .clk(clk), .rst(rst), .valid_in(valid_in), .stall_in(stall_in), .command(command),
  .valid_out(valid_out), .stall_out(stall_out), .surface_height(surface_height),
  .in_material(in_material), .divide_by_zero(divide_by_zero)
);
